@@ design/i2cse_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cse_pkg
// Shared types, status decode masks and the bus event decoder for the
// I2C slave event engine.
// ----------------------------------------------------------------------------
package i2cse_pkg;

	// default depth of the receive and transmit stores
	localparam int BUFFER_DEPTH_DEF = 32;

	// field widths of one word
	localparam int STATUS_W   = 8;
	localparam int BYTE_W     = 8;
	localparam int HIDX_W     = 5;
	localparam int MSG_LEN_W  = 6;

	// item selector carried in tuser on the input side
	typedef enum logic [1:0] {
		ACT_BUS      = 2'd0,
		ACT_TX_WRITE = 2'd1,
		ACT_RX_READ  = 2'd2
	} action_t;

	// result kind carried in tuser on the output side
	typedef enum logic [3:0] {
		KIND_START  = 4'd0,
		KIND_STOP   = 4'd1,
		KIND_AWRITE = 4'd2,
		KIND_DWRITE = 4'd3,
		KIND_AREAD  = 4'd4,
		KIND_DREAD  = 4'd5,
		KIND_NACK   = 4'd6,
		KIND_ERROR  = 4'd7,
		KIND_HOST   = 4'd8
	} event_kind_t;

	// status register decode masks and match values
	localparam logic [7:0] START_MASK = 8'b0000_1111;
	localparam logic [7:0] START_VAL  = 8'b0000_1000;
	localparam logic [7:0] STOP_MASK  = 8'b0011_0000;
	localparam logic [7:0] STATE_MASK = 8'b0010_1101;
	localparam logic [7:0] AWRITE_VAL = 8'b0000_1001;
	localparam logic [7:0] DWRITE_VAL = 8'b0010_1001;
	localparam logic [7:0] DWRITE_SET = 8'b0000_1000;
	localparam logic [7:0] AREAD_MASK = 8'b1111_1110;
	localparam logic [7:0] AREAD_VAL  = 8'b0000_1100;
	localparam logic [7:0] DREAD_MASK = 8'b1111_1011;
	localparam logic [7:0] DREAD_VAL  = 8'b0010_1000;

	// per-word result info handed from control to the pipeline
	typedef struct packed {
		event_kind_t          kind;
		logic                 send_valid;
		logic                 msg_valid;
		logic [MSG_LEN_W-1:0] msg_len;
		logic                 req_valid;
		logic                 rd_valid;
		logic                 error;
	} res_t;

	// classify a bus event; order of tests decides
	function automatic event_kind_t decode_status(input logic [7:0] status,
		input logic held);
		logic [7:0] t;
		event_kind_t k;
		t = status & STATE_MASK;
		priority if ((status & START_MASK) == START_VAL) k = KIND_START;
		else if ((status & STOP_MASK) == STOP_MASK) k = KIND_STOP;
		else if (t == AWRITE_VAL) k = KIND_AWRITE;
		else if ((t | DWRITE_SET) == DWRITE_VAL) k = KIND_DWRITE;
		else if ((t & AREAD_MASK) == AREAD_VAL) k = KIND_AREAD;
		else if ((t & DREAD_MASK) == DREAD_VAL) k = held ? KIND_DREAD : KIND_NACK;
		else k = KIND_ERROR;
		return k;
	endfunction

endpackage

@@ design/i2cse_store.sv @@
// ----------------------------------------------------------------------------
// i2cse_store
// Byte store with one write port and one registered read port. Entries not
// yet written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module i2cse_store #(
	parameter int DEPTH = i2cse_pkg::BUFFER_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rdata_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// registered read, unwritten entries give zero
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : 8'd0;
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/i2cse_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2cse_ctrl
// Event decode, receive/transmit pointers and flags. Issues the store
// accesses for each accepted word and builds its result info.
// ----------------------------------------------------------------------------
module i2cse_ctrl #(
	parameter int DEPTH = i2cse_pkg::BUFFER_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int PW = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  i2cse_pkg::action_t             action,
	input  logic [i2cse_pkg::STATUS_W-1:0] status,
	input  logic [7:0]                     bus_byte,
	input  logic                           clock_held,
	input  logic                           overrun,
	input  logic [i2cse_pkg::HIDX_W-1:0]   host_index,
	input  logic [7:0]                     host_data,
	// receive store access
	output logic                           rx_we,
	output logic [AW-1:0]                  rx_waddr,
	output logic [7:0]                     rx_wdata,
	output logic                           rx_re,
	output logic [AW-1:0]                  rx_raddr,
	// transmit store access
	output logic                           tx_we,
	output logic [AW-1:0]                  tx_waddr,
	output logic [7:0]                     tx_wdata,
	output logic                           tx_re,
	output logic [AW-1:0]                  tx_raddr,
	output i2cse_pkg::res_t                res
);

	logic [PW-1:0] rx_ptr_q, rx_ptr_d;
	logic [AW-1:0] tx_ptr_q, tx_ptr_d;
	logic          pending_q, pending_d;
	logic          err_q, err_d;

	i2cse_pkg::event_kind_t kind;
	logic                   host_ok;
	logic                   hand_over;
	logic                   is_send;

	// classify the word
	always_comb begin
		kind = (action == i2cse_pkg::ACT_BUS) ?
			i2cse_pkg::decode_status(status, clock_held) : i2cse_pkg::KIND_HOST;
		host_ok   = int'(host_index) < DEPTH;
		hand_over = (kind == i2cse_pkg::KIND_STOP) || (kind == i2cse_pkg::KIND_AWRITE);
		is_send   = (kind == i2cse_pkg::KIND_AREAD) || (kind == i2cse_pkg::KIND_DREAD);
	end

	// store accesses
	always_comb begin
		rx_we    = accept && (kind == i2cse_pkg::KIND_DWRITE) && !overrun;
		rx_waddr = (rx_ptr_q >= PW'(DEPTH - 1)) ? AW'(DEPTH - 1) : AW'(rx_ptr_q);
		rx_wdata = bus_byte;
		rx_re    = accept && (action == i2cse_pkg::ACT_RX_READ) && host_ok;
		rx_raddr = AW'(host_index);
		tx_we    = accept && (action == i2cse_pkg::ACT_TX_WRITE) && host_ok;
		tx_waddr = AW'(host_index);
		tx_wdata = host_data;
		tx_re    = accept && is_send;
		tx_raddr = (kind == i2cse_pkg::KIND_AREAD) ? '0 : tx_ptr_q;
	end

	// pointer and flag updates
	always_comb begin
		rx_ptr_d  = rx_ptr_q;
		tx_ptr_d  = tx_ptr_q;
		pending_d = pending_q;
		err_d     = err_q;
		unique case (kind)
			i2cse_pkg::KIND_STOP, i2cse_pkg::KIND_AWRITE: begin
				rx_ptr_d  = '0;
				pending_d = 1'b0;
			end
			i2cse_pkg::KIND_DWRITE: begin
				pending_d = 1'b1;
				if (!overrun && (rx_ptr_q < PW'(DEPTH))) begin
					rx_ptr_d = rx_ptr_q + PW'(1);
				end
			end
			i2cse_pkg::KIND_AREAD: begin
				tx_ptr_d = AW'(1);
			end
			i2cse_pkg::KIND_DREAD: begin
				if (tx_ptr_q < AW'(DEPTH - 1)) begin
					tx_ptr_d = tx_ptr_q + AW'(1);
				end
			end
			i2cse_pkg::KIND_ERROR: begin
				err_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ptr_q  <= '0;
			tx_ptr_q  <= '0;
			pending_q <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			rx_ptr_q  <= rx_ptr_d;
			tx_ptr_q  <= tx_ptr_d;
			pending_q <= pending_d;
			err_q     <= err_d;
		end
	end

	// result info for this word
	always_comb begin
		res.kind       = kind;
		res.send_valid = is_send;
		res.msg_valid  = hand_over && pending_q;
		res.msg_len    = (hand_over && pending_q) ? i2cse_pkg::MSG_LEN_W'(rx_ptr_q) : '0;
		res.req_valid  = (kind == i2cse_pkg::KIND_AREAD);
		res.rd_valid   = (action == i2cse_pkg::ACT_RX_READ) && host_ok;
		res.error      = err_d;
	end

endmodule

@@ design/i2c_slave_event_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_slave_event_engine
// I2C slave byte-level event engine: status decode, receive and transmit
// byte stores, message handover and host access to both stores.
// ----------------------------------------------------------------------------
// One input word is accepted every clock cycle unless the input stalls, and
// every word yields exactly one output word. A word passes through stage 1,
// where the registered read of the receive or transmit store lands, and the
// result then moves to the output register. Both stores are written and read
// at the cycle a word is accepted, so back-to-back words always see the
// effect of the word before them. Stores read as zero until written; reset
// takes effect at once, with no clearing pass. While a finished result waits
// in the output register, the input takes one more word into stage 1 and then
// stalls until the output word is taken.
// ----------------------------------------------------------------------------
module i2c_slave_event_engine #(
	parameter int BUFFER_DEPTH = i2cse_pkg::BUFFER_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// status[7:0], bus_byte[15:8], clock_held[16], overrun[17],
	// host_index[22:18], host_data[30:23], zero[31]
	input  logic [31:0] s_tdata,
	// action[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// send_valid[0], send_byte[8:1], message_valid[9], message_length[15:10],
	// request_valid[16], read_data[24:17], error_flag[25], zero[31:26]
	output logic [31:0] m_tdata,
	// event_kind[3:0]
	output logic [3:0]  m_tuser
);

	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic            accept;
	logic            s1_valid;
	logic            s1_move;
	i2cse_pkg::res_t res;
	i2cse_pkg::res_t res_s1;
	logic            out_valid_q;
	logic [31:0]     tdata_q;
	logic [3:0]      tuser_q;

	logic          rx_we, rx_re, tx_we, tx_re;
	logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
	logic [7:0]    rx_wdata, tx_wdata, rx_rdata, tx_rdata;
	logic [7:0]    send_byte, read_data;

	// handshake: stage 1 frees when the output register can take it
	assign s1_move  = s1_valid && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid || s1_move;
	assign accept   = s_tvalid && s_tready;

	i2cse_ctrl #(
		.DEPTH(BUFFER_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (i2cse_pkg::action_t'(s_tuser)),
		.status     (s_tdata[7:0]),
		.bus_byte   (s_tdata[15:8]),
		.clock_held (s_tdata[16]),
		.overrun    (s_tdata[17]),
		.host_index (s_tdata[22:18]),
		.host_data  (s_tdata[30:23]),
		.rx_we      (rx_we),
		.rx_waddr   (rx_waddr),
		.rx_wdata   (rx_wdata),
		.rx_re      (rx_re),
		.rx_raddr   (rx_raddr),
		.tx_we      (tx_we),
		.tx_waddr   (tx_waddr),
		.tx_wdata   (tx_wdata),
		.tx_re      (tx_re),
		.tx_raddr   (tx_raddr),
		.res        (res)
	);

	i2cse_store #(
		.DEPTH(BUFFER_DEPTH)
	) u_rx_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (rx_we),
		.waddr  (rx_waddr),
		.wdata  (rx_wdata),
		.re     (rx_re),
		.raddr  (rx_raddr),
		.rdata  (rx_rdata)
	);

	i2cse_store #(
		.DEPTH(BUFFER_DEPTH)
	) u_tx_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (tx_we),
		.waddr  (tx_waddr),
		.wdata  (tx_wdata),
		.re     (tx_re),
		.raddr  (tx_raddr),
		.rdata  (tx_rdata)
	);

	// stage 1: result info, aligned with the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_move) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// mask store data for words that did not read
	assign send_byte = res_s1.send_valid ? tx_rdata : 8'd0;
	assign read_data = res_s1.rd_valid ? rx_rdata : 8'd0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			tdata_q <= {6'd0, res_s1.error, read_data, res_s1.req_valid,
				res_s1.msg_len, res_s1.msg_valid, send_byte, res_s1.send_valid};
			tuser_q <= res_s1.kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

endmodule
